FILE: rtl/remote_link_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// remote link frame receiver assertion macros
// shared concurrent assertion forms, clocked on clk, held off during reset
// ----------------------------------------------------------------------------
`ifndef REMOTE_LINK_FRAME_RECEIVER_DEFINES_SVH
`define REMOTE_LINK_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication
`define RLFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RLFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rlfr_pkg.sv
// ----------------------------------------------------------------------------
// rlfr_pkg
// types and constants shared by the remote link frame receiver modules
// ----------------------------------------------------------------------------
package rlfr_pkg;

    // framing and request codes
    localparam logic [7:0]  MARK_BYTE     = 8'hFF;
    localparam logic [7:0]  REQ_LEFT      = 8'hBB;
    localparam logic [7:0]  REQ_RIGHT     = 8'hCC;
    localparam logic [7:0]  STOP_HDR      = 8'hAA;
    localparam logic [7:0]  NO_BYTE       = 8'h00;
    localparam logic [7:0]  CENTRE        = 8'd127;
    localparam logic [1:0]  PAYLOAD_LEN   = 2'd3;
    localparam logic [15:0] TIMEOUT_RESET = 16'd180;
    localparam logic [15:0] WAIT_MAX      = 16'hFFFF;
    localparam logic [1:0]  QUEUE_DEPTH   = 2'd2;

    // link phase
    typedef enum logic [1:0] {
        LINK_IDLE  = 2'd0,
        LINK_LEFT  = 2'd1,
        LINK_RIGHT = 2'd2
    } link_state_t;

    // command kinds passed from front to back
    typedef enum logic [1:0] {
        CMD_NOP   = 2'd0,
        CMD_FRAME = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [7:0] left_y;
        logic [7:0] left_x;
        logic [7:0] right_y;
        logic [7:0] right_x;
        logic [1:0] link_phase;
        logic [1:0] stop_phase;
        logic       start_seen;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] hdr;
        logic [7:0] p1;
        logic [7:0] p2;
    } cmd_t;

endpackage

FILE: rtl/remote_link_frame_receiver.sv
// ----------------------------------------------------------------------------
// remote_link_frame_receiver
// polled joystick link: deframes answer bytes, issues poll requests on ticks
// ----------------------------------------------------------------------------
// Up to one beat is accepted every clock cycle while full is low, and each
// beat gives exactly one result beat; an accepted beat is registered into
// the two-entry command queue between deframer and link engine, and its
// result is registered from there into the engine's two-entry result queue,
// from which it is popped. full rises only when both queues are backed up
// by a stalled pop. The configuration channel is always ready and writes
// the 16-bit answer timeout in ticks.
// ----------------------------------------------------------------------------
module remote_link_frame_receiver
    import rlfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    item,
    output logic        empty,
    input  logic        pop,
    output out_item_t   result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic    accept;
    cmd_t    front_cmd;
    cmd_t    queue_cmd;
    logic    cmd_avail;
    logic    cmd_take;

    assign accept    = push && !full;
    assign cfg_ready = 1'b1;

    // deframer
    rlfr_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cmd    (front_cmd)
    );

    // command queue
    rlfr_cmd_queue u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_cmd   (front_cmd),
        .full     (full),
        .rd_take  (cmd_take),
        .rd_avail (cmd_avail),
        .rd_cmd   (queue_cmd)
    );

    // link engine
    rlfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (queue_cmd),
        .cmd_avail (cmd_avail),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

FILE: rtl/rlfr_front.sv
// ----------------------------------------------------------------------------
// rlfr_front
// deframer: accepts input beats and turns each into one command
// ----------------------------------------------------------------------------
module rlfr_front
    import rlfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t item,
    output cmd_t     cmd
);

    logic       in_frame_reg;
    logic       in_frame_next;
    logic [1:0] byte_count_reg;
    logic [1:0] byte_count_next;
    logic [7:0] payload_reg [3];
    logic       payload_wr;

    // classify the beat and update framing state
    always_comb
    begin
        in_frame_next   = in_frame_reg;
        byte_count_next = byte_count_reg;
        payload_wr      = 1'b0;
        cmd.kind        = CMD_NOP;
        cmd.hdr         = payload_reg[0];
        cmd.p1          = payload_reg[1];
        cmd.p2          = payload_reg[2];
        if (item.mode)
        begin
            cmd.kind = CMD_TICK;
        end
        else if (!in_frame_reg)
        begin
            if (item.rx_byte == MARK_BYTE)
            begin
                in_frame_next = 1'b1;
            end
            byte_count_next = 2'd0;
        end
        else if (byte_count_reg < PAYLOAD_LEN)
        begin
            payload_wr      = 1'b1;
            byte_count_next = byte_count_reg + 2'd1;
        end
        else if (item.rx_byte == MARK_BYTE)
        begin
            in_frame_next   = 1'b0;
            byte_count_next = 2'd0;
            cmd.kind        = CMD_FRAME;
        end
    end

    // framing control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            byte_count_reg <= 2'd0;
        end
        else if (accept)
        begin
            in_frame_reg   <= in_frame_next;
            byte_count_reg <= byte_count_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept && payload_wr)
        begin
            payload_reg[byte_count_reg] <= item.rx_byte;
        end
    end

endmodule

FILE: rtl/rlfr_cmd_queue.sv
// ----------------------------------------------------------------------------
// rlfr_cmd_queue
// two-entry command queue between the deframer and the link engine
// ----------------------------------------------------------------------------
module rlfr_cmd_queue
    import rlfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  cmd_t    wr_cmd,
    output logic    full,
    input  logic    rd_take,
    output logic    rd_avail,
    output cmd_t    rd_cmd
);

    cmd_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign full     = (count_reg == QUEUE_DEPTH);
    assign rd_avail = (count_reg != 2'd0);
    assign rd_cmd   = mem[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_take && rd_avail;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

FILE: rtl/rlfr_back.sv
// ----------------------------------------------------------------------------
// rlfr_back
// link engine: runs frame and tick commands, queues one result per command
// ----------------------------------------------------------------------------
module rlfr_back
    import rlfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr,
    input  logic [15:0] cfg_data,
    input  cmd_t        cmd,
    input  logic        cmd_avail,
    output logic        cmd_take,
    output logic        empty,
    input  logic        pop,
    output out_item_t   result
);

    `include "remote_link_frame_receiver_defines.svh"

    logic [15:0] timeout_reg;
    link_state_t link_reg;
    link_state_t link_next;
    logic [15:0] left_wait_reg;
    logic [15:0] left_wait_next;
    logic [15:0] right_wait_reg;
    logic [15:0] right_wait_next;
    logic [7:0]  left_y_reg;
    logic [7:0]  left_y_next;
    logic [7:0]  left_x_reg;
    logic [7:0]  left_x_next;
    logic [7:0]  right_y_reg;
    logic [7:0]  right_y_next;
    logic [7:0]  right_x_reg;
    logic [7:0]  right_x_next;
    logic [1:0]  stop_reg;
    logic [1:0]  stop_next;
    logic        start_reg;
    logic        start_next;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        recentre;
    out_item_t   res_item;

    out_item_t   res_mem [2];
    logic        res_wr_ptr_reg;
    logic        res_rd_ptr_reg;
    logic [1:0]  res_count_reg;
    logic        pop_fire;
    logic        res_space;
    logic        take;

    // result queue handshake
    assign empty     = (res_count_reg == 2'd0);
    assign pop_fire  = pop && !empty;
    assign res_space = (res_count_reg != QUEUE_DEPTH) || pop_fire;
    assign take      = cmd_avail && res_space;
    assign cmd_take  = take;
    assign result    = res_mem[res_rd_ptr_reg];

    // command execution
    always_comb
    begin
        link_next       = link_reg;
        left_wait_next  = left_wait_reg;
        right_wait_next = right_wait_reg;
        left_y_next     = left_y_reg;
        left_x_next     = left_x_reg;
        right_y_next    = right_y_reg;
        right_x_next    = right_x_reg;
        stop_next       = stop_reg;
        start_next      = start_reg;
        tx_valid        = 1'b0;
        tx_byte         = NO_BYTE;
        recentre        = 1'b0;
        unique case (cmd.kind)
            CMD_FRAME:
            begin
                if (cmd.hdr == REQ_LEFT)
                begin
                    if (link_reg == LINK_LEFT)
                    begin
                        left_y_next = cmd.p1;
                        left_x_next = cmd.p2;
                        link_next   = LINK_RIGHT;
                        tx_valid    = 1'b1;
                        tx_byte     = REQ_RIGHT;
                    end
                end
                else if (cmd.hdr == REQ_RIGHT)
                begin
                    if (link_reg == LINK_RIGHT)
                    begin
                        right_y_next = cmd.p1;
                        right_x_next = cmd.p2;
                        link_next    = LINK_IDLE;
                    end
                end
                else
                begin
                    recentre  = 1'b1;
                    link_next = LINK_IDLE;
                    if (cmd.hdr == STOP_HDR)
                    begin
                        stop_next  = stop_reg + 2'd1;
                        start_next = 1'b1;
                    end
                end
            end
            CMD_TICK:
            begin
                if (stop_reg == 2'd0)
                begin
                    // an idle link gets a left request first
                    if (link_reg == LINK_IDLE)
                    begin
                        link_next = LINK_LEFT;
                        tx_valid  = 1'b1;
                        tx_byte   = REQ_LEFT;
                    end
                    unique case (link_next)
                        LINK_LEFT:
                        begin
                            if (left_wait_reg != WAIT_MAX)
                            begin
                                left_wait_next = left_wait_reg + 16'd1;
                            end
                            right_wait_next = 16'd0;
                        end
                        LINK_RIGHT:
                        begin
                            left_wait_next = 16'd0;
                            if (right_wait_reg != WAIT_MAX)
                            begin
                                right_wait_next = right_wait_reg + 16'd1;
                            end
                        end
                        default:
                        begin
                            left_wait_next  = 16'd0;
                            right_wait_next = 16'd0;
                        end
                    endcase
                    // answer timeout
                    if (left_wait_next >= timeout_reg || right_wait_next >= timeout_reg)
                    begin
                        recentre        = 1'b1;
                        link_next       = LINK_IDLE;
                        left_wait_next  = 16'd0;
                        right_wait_next = 16'd0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (recentre)
        begin
            left_y_next  = CENTRE;
            left_x_next  = CENTRE;
            right_y_next = CENTRE;
            right_x_next = CENTRE;
        end
        res_item.tx_valid   = tx_valid;
        res_item.tx_byte    = tx_byte;
        res_item.left_y     = left_y_next;
        res_item.left_x     = left_x_next;
        res_item.right_y    = right_y_next;
        res_item.right_x    = right_x_next;
        res_item.link_phase = link_next;
        res_item.stop_phase = stop_next;
        res_item.start_seen = start_next;
    end

    // link state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg       <= LINK_IDLE;
            left_wait_reg  <= 16'd0;
            right_wait_reg <= 16'd0;
            left_y_reg     <= CENTRE;
            left_x_reg     <= CENTRE;
            right_y_reg    <= CENTRE;
            right_x_reg    <= CENTRE;
            stop_reg       <= 2'd0;
            start_reg      <= 1'b0;
        end
        else if (take)
        begin
            link_reg       <= link_next;
            left_wait_reg  <= left_wait_next;
            right_wait_reg <= right_wait_next;
            left_y_reg     <= left_y_next;
            left_x_reg     <= left_x_next;
            right_y_reg    <= right_y_next;
            right_x_reg    <= right_x_next;
            stop_reg       <= stop_next;
            start_reg      <= start_next;
        end
    end

    // timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr)
        begin
            timeout_reg <= cfg_data;
        end
    end

    // result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_ptr_reg <= 1'b0;
            res_rd_ptr_reg <= 1'b0;
            res_count_reg  <= 2'd0;
        end
        else
        begin
            if (take)
            begin
                res_wr_ptr_reg <= !res_wr_ptr_reg;
            end
            if (pop_fire)
            begin
                res_rd_ptr_reg <= !res_rd_ptr_reg;
            end
            if (take && !pop_fire)
            begin
                res_count_reg <= res_count_reg + 2'd1;
            end
            else if (pop_fire && !take)
            begin
                res_count_reg <= res_count_reg - 2'd1;
            end
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_mem[res_wr_ptr_reg] <= res_item;
        end
    end

    // checks
    `RLFR_ASSERT_NOW(a_tx_code, take && tx_valid,
        tx_byte == REQ_LEFT || tx_byte == REQ_RIGHT, "bad request code")
    `RLFR_ASSERT_NEXT(a_stop_hold, take && cmd.kind == CMD_TICK && stop_reg != 2'd0,
        $stable(link_reg) && $stable(left_wait_reg), "tick moved suspended link")
    `RLFR_ASSERT_NOW(a_one_wait, 1'b1,
        left_wait_reg == 16'd0 || right_wait_reg == 16'd0, "both wait counters running")
    `RLFR_ASSERT_NOW(a_res_bound, 1'b1, res_count_reg <= QUEUE_DEPTH, "result queue overflow")

endmodule

FILE: bench/rlfr_link_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlfr_link_monitor
// watches the item, result and timeout channels of the remote link frame
// receiver, keeps its own copy of the deframer and poll engine, works out the
// result due for every accepted item and compares each popped result with it
// ----------------------------------------------------------------------------
module rlfr_link_monitor
    import rlfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  in_item_t    item,
    input  logic        empty,
    input  logic        pop,
    input  out_item_t   result,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          mismatch_count,
    output int          reports_due,
    output int          reports_checked,
    output logic [1:0]  stop_hint
);

    // own copy of the link state
    logic [15:0]  answer_timeout;
    logic         framing;
    logic [1:0]   frame_fill;
    logic [7:0]   frame_bytes [3];
    link_state_t  link;
    logic [15:0]  left_ticks;
    logic [15:0]  right_ticks;
    logic [7:0]   sticks [4];
    logic [1:0]   stop_phase_q;
    logic         started;

    out_item_t    link_reports_due [$];
    out_item_t    due_report;
    out_item_t    new_report;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t  mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string field_name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("result %0d field %s: got %0h, expected %0h",
                                      reports_checked, field_name, got, want));
    endtask

    task automatic centre_sticks();
        for (int i = 0; i < 4; i++)
            sticks[i] = CENTRE;
    endtask

    // one item through the deframer or the poll engine
    task automatic step_remote_link(input in_item_t beat, output out_item_t rep);
        logic       sent;
        logic [7:0] sent_byte;
        sent      = 1'b0;
        sent_byte = NO_BYTE;
        if (!beat.mode) begin
            if (!framing) begin
                // outside a frame only the opening mark matters
                if (beat.rx_byte == MARK_BYTE)
                    framing = 1'b1;
                frame_fill = 2'd0;
            end else if (frame_fill < PAYLOAD_LEN) begin
                frame_bytes[frame_fill] = beat.rx_byte;
                frame_fill++;
            end else if (beat.rx_byte == MARK_BYTE) begin
                // closing mark: act on the header
                framing    = 1'b0;
                frame_fill = 2'd0;
                case (frame_bytes[0])
                    REQ_LEFT: begin
                        if (link == LINK_LEFT) begin
                            sticks[0] = frame_bytes[1];
                            sticks[1] = frame_bytes[2];
                            link      = LINK_RIGHT;
                            sent      = 1'b1;
                            sent_byte = REQ_RIGHT;
                        end
                    end
                    REQ_RIGHT: begin
                        if (link == LINK_RIGHT) begin
                            sticks[2] = frame_bytes[1];
                            sticks[3] = frame_bytes[2];
                            link      = LINK_IDLE;
                        end
                    end
                    default: begin
                        centre_sticks();
                        link = LINK_IDLE;
                    end
                endcase
                if (frame_bytes[0] == STOP_HDR) begin
                    stop_phase_q++;
                    started = 1'b1;
                end
            end
        end else if (stop_phase_q == 2'd0) begin
            // poll tick
            if (link == LINK_IDLE) begin
                link      = LINK_LEFT;
                sent      = 1'b1;
                sent_byte = REQ_LEFT;
            end
            case (link)
                LINK_LEFT: begin
                    if (left_ticks != WAIT_MAX)
                        left_ticks++;
                    right_ticks = '0;
                end
                LINK_RIGHT: begin
                    left_ticks = '0;
                    if (right_ticks != WAIT_MAX)
                        right_ticks++;
                end
                default: begin
                    left_ticks  = '0;
                    right_ticks = '0;
                end
            endcase
            if (left_ticks >= answer_timeout || right_ticks >= answer_timeout) begin
                centre_sticks();
                link        = LINK_IDLE;
                left_ticks  = '0;
                right_ticks = '0;
            end
        end
        rep.tx_valid   = sent;
        rep.tx_byte    = sent_byte;
        rep.left_y     = sticks[0];
        rep.left_x     = sticks[1];
        rep.right_y    = sticks[2];
        rep.right_x    = sticks[3];
        rep.link_phase = link;
        rep.stop_phase = stop_phase_q;
        rep.start_seen = started;
    endtask

    // watch all three channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            answer_timeout = TIMEOUT_RESET;
            framing        = 1'b0;
            frame_fill     = 2'd0;
            for (int i = 0; i < 3; i++)
                frame_bytes[i] = 8'd0;
            link           = LINK_IDLE;
            left_ticks     = '0;
            right_ticks    = '0;
            centre_sticks();
            stop_phase_q   = 2'd0;
            started        = 1'b0;
            link_reports_due.delete();
            mismatch_count  = 0;
            reports_checked = 0;
            reports_due <= 0;
            stop_hint   <= 2'd0;
        end
        else
        begin
            // result beat against the oldest expectation
            if (pop && !empty)
            begin
                if (link_reports_due.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    due_report = link_reports_due.pop_front();
                    check_field("tx_valid",   result.tx_valid,   due_report.tx_valid);
                    check_field("tx_byte",    result.tx_byte,    due_report.tx_byte);
                    check_field("left_y",     result.left_y,     due_report.left_y);
                    check_field("left_x",     result.left_x,     due_report.left_x);
                    check_field("right_y",    result.right_y,    due_report.right_y);
                    check_field("right_x",    result.right_x,    due_report.right_x);
                    check_field("link_phase", result.link_phase, due_report.link_phase);
                    check_field("stop_phase", result.stop_phase, due_report.stop_phase);
                    check_field("start_seen", result.start_seen, due_report.start_seen);
                    reports_checked++;
                end
            end
            // timeout register write
            if (cfg_valid && cfg_ready)
                answer_timeout = cfg_data;
            // accepted item
            if (push && !full)
            begin
                step_remote_link(item, new_report);
                link_reports_due.push_back(new_report);
            end
            reports_due <= link_reports_due.size();
            stop_hint   <= stop_phase_q;
        end
    end

endmodule

FILE: bench/tb_remote_link_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_remote_link_frame_receiver
// drives answer frames, noise and poll ticks into the remote link frame
// receiver under several answer timeouts, with random gaps and stalls on
// both queues and one long result hold-off; the link monitor checks results
// ----------------------------------------------------------------------------
module tb_remote_link_frame_receiver;
    import rlfr_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    in_item_t    item;
    logic        empty;
    logic        pop;
    out_item_t   result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    int          mismatch_count;
    int          reports_due;
    int          reports_checked;
    logic [1:0]  stop_hint;

    int          gap_pct;
    int          stall_pct;
    bit          hold_off;
    int          beats_sent;
    int          ticks_sent;
    int          frames_sent;
    int          timeouts_written;

    logic [15:0] timeout_plan [6] = '{16'd0, 16'd1, 16'd3, 16'hFFFF, 16'd12, 16'd180};

    remote_link_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    rlfr_link_monitor u_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .item            (item),
        .empty           (empty),
        .pop             (pop),
        .result          (result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .reports_due     (reports_due),
        .reports_checked (reports_checked),
        .stop_hint       (stop_hint)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // one item beat, with random idle cycles ahead of it
    task automatic send_beat(input logic mode, input logic [7:0] data);
        while ($urandom_range(99) < gap_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= in_item_t'{mode, data};
        do
            @(posedge clk);
        while (full);
        beats_sent++;
        if (mode)
            ticks_sent++;
    endtask

    // mark, header, two stick bytes, optional dropped bytes, closing mark
    task automatic send_frame(input logic [7:0] hdr, input logic [7:0] p1,
                              input logic [7:0] p2, input int extra);
        send_beat(1'b0, MARK_BYTE);
        send_beat(1'b0, hdr);
        send_beat(1'b0, p1);
        send_beat(1'b0, p2);
        repeat (extra)
            send_beat(1'b0, 8'($urandom_range(0, 254)));
        send_beat(1'b0, MARK_BYTE);
        frames_sent++;
    endtask

    // mostly ticks and well-formed answers, some noise and cut-off frames
    task automatic send_random_sequence();
        int          pick;
        int          hdr_pick;
        logic [7:0]  hdr;
        pick = $urandom_range(99);
        if (stop_hint != 2'd0 && pick < 60)
            send_frame(STOP_HDR, 8'($urandom), 8'($urandom), 0);
        else if (pick < 40)
            repeat ($urandom_range(1, 3))
                send_beat(1'b1, 8'($urandom));
        else if (pick < 86)
        begin
            hdr_pick = $urandom_range(99);
            if (hdr_pick < 38)
                hdr = REQ_LEFT;
            else if (hdr_pick < 76)
                hdr = REQ_RIGHT;
            else if (hdr_pick < 82)
                hdr = STOP_HDR;
            else
                hdr = 8'($urandom);
            send_frame(hdr, 8'($urandom), 8'($urandom),
                       ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0);
        end
        else if (pick < 93)
            repeat ($urandom_range(1, 4))
                send_beat(1'b0, 8'($urandom));
        else
        begin
            // frame cut off before its closing mark
            send_beat(1'b0, MARK_BYTE);
            send_beat(1'b0, ($urandom_range(1) == 0) ? REQ_LEFT : REQ_RIGHT);
            send_beat(1'b0, 8'($urandom));
        end
    endtask

    task automatic run_random_traffic(input int beats);
        int first;
        first = beats_sent;
        while (beats_sent - first < beats)
            send_random_sequence();
    endtask

    // stop offering and wait for every result to come back
    task automatic drain_results(input int extra_cycles);
        push <= 1'b0;
        do
            @(posedge clk);
        while (reports_due != 0);
        repeat (extra_cycles)
            @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] ticks);
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        timeouts_written++;
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                hold_off = 1'b0;
                pop <= 1'b0;
                repeat (300)
                    @(posedge clk);
            end
            else
                pop <= rst_n && ($urandom_range(99) >= stall_pct);
        end
    end

    // run limit
    initial
    begin
        #50_000_000;
        $display("timeout with %0d results outstanding", reports_due);
        $display("end of test: mismatches");
        $finish;
    end

    // stimulus
    initial
    begin
        rst_n            = 1'b0;
        push             = 1'b0;
        item             = '0;
        cfg_valid        = 1'b0;
        cfg_data         = '0;
        gap_pct          = 28;
        stall_pct        = 28;
        hold_off         = 1'b0;
        beats_sent       = 0;
        ticks_sent       = 0;
        frames_sent      = 0;
        timeouts_written = 0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_timeout(TIMEOUT_RESET);

        // directed: stray byte, poll, left answer with a mark in the payload
        // and a dropped byte, tick, right answer, unexpected answer, stop frame, tick
        send_beat(1'b0, 8'h00);
        send_beat(1'b1, 8'hFF);
        send_beat(1'b0, MARK_BYTE);
        send_beat(1'b0, REQ_LEFT);
        send_beat(1'b0, 8'h00);
        send_beat(1'b0, MARK_BYTE);
        send_beat(1'b0, 8'h5A);
        send_beat(1'b0, MARK_BYTE);
        frames_sent++;
        send_beat(1'b1, 8'h00);
        send_frame(REQ_RIGHT, 8'h80, 8'h01, 0);
        send_frame(REQ_LEFT, 8'h01, 8'h02, 0);
        send_frame(STOP_HDR, 8'hFF, 8'hFF, 0);
        send_beat(1'b1, 8'h00);
        drain_results(4);

        // random traffic under each timeout setting
        foreach (timeout_plan[i])
        begin
            gap_pct   = (i == 2) ? 0 : 28;
            stall_pct = (i == 2) ? 0 : 28;
            write_timeout((i == 4) ? 16'($urandom_range(2, 40)) : timeout_plan[i]);
            if (i == 1)
                hold_off = 1'b1;
            if (i == 3)
            begin
                // resume polling, then let the wait counter run for a while
                while (stop_hint != 2'd0)
                begin
                    send_frame(STOP_HDR, 8'($urandom), 8'($urandom), 0);
                    push <= 1'b0;
                    @(posedge clk);
                end
                repeat (40)
                    send_beat(1'b1, 8'($urandom));
            end
            run_random_traffic(165);
            drain_results(4);
        end

        drain_results(10);
        $display("covered %0d item beats (%0d ticks, %0d frames) over %0d timeout settings",
                 beats_sent, ticks_sent, frames_sent, timeouts_written);
        $display("%0d results compared, including a 300-cycle result hold-off",
                 reports_checked);
        if (mismatch_count == 0 && reports_due == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
